[rtl/great_circle_distance_macros.svh]
`ifndef GREAT_CIRCLE_DISTANCE_MACROS_SVH
`define GREAT_CIRCLE_DISTANCE_MACROS_SVH

// same-cycle implication, disabled in reset
`define GCD_ASSERT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define GCD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// state right after a reset cycle
`define GCD_ASSERT_RST(label, clk, rst, cons, msg) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

[rtl/gcd_pkg.sv]
`default_nettype none
package gcd_pkg;

  localparam int LAT_W  = 24;
  localparam int LON_W  = 26;
  localparam int DIST_W = 25;
  localparam int RAD_W  = 23;
  localparam int ANG_W  = 34;
  localparam int THETA_W = 32;
  localparam int SQRT_W = 31;
  localparam int CORDIC_STAGES_DEF = 24;

  typedef logic signed [ANG_W-1:0] ang_t;

  localparam logic [RAD_W-1:0]  RADIUS_RESET = 23'd6378137;
  localparam logic [DIST_W-1:0] DIST_MAX     = 25'd26353600;
  localparam ang_t INV_GAIN = 34'sd652032874;
  localparam ang_t HALF_PI  = 34'sd1686629713;
  localparam ang_t ONE_Q30  = 34'sd1073741824;

  typedef struct packed {
    logic valid;
    logic zero;
    logic missing;
  } ctl_t;

  function automatic ang_t atan_step(input int i);
    ang_t r;
    case (i)
      0:  r = 34'sd843314857;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043837;
      3:  r = 34'sd133525159;
      4:  r = 34'sd67021687;
      5:  r = 34'sd33543516;
      6:  r = 34'sd16775851;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194283;
      9:  r = 34'sd2097149;
      10: r = 34'sd1048576;
      default: r = (i <= 30) ? (ang_t'(1) << (30 - i)) : '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/gcd_ifs.sv]
`default_nettype none
interface gcd_pts_if;
  logic valid;
  logic ready;
  logic signed [gcd_pkg::LAT_W-1:0] lat_a;
  logic signed [gcd_pkg::LON_W-1:0] lon_a;
  logic signed [gcd_pkg::LAT_W-1:0] lat_b;
  logic signed [gcd_pkg::LON_W-1:0] lon_b;
  logic a_missing;
  logic b_missing;
  modport source(output valid, lat_a, lon_a, lat_b, lon_b, a_missing, b_missing,
                 input ready);
  modport sink(input valid, lat_a, lon_a, lat_b, lon_b, a_missing, b_missing,
               output ready);
endinterface

interface gcd_res_if;
  logic valid;
  logic ready;
  logic [gcd_pkg::DIST_W-1:0] distance_m;
  logic result_missing;
  modport source(output valid, distance_m, result_missing, input ready);
  modport sink(input valid, distance_m, result_missing, output ready);
endinterface

interface gcd_cfg_if;
  logic valid;
  logic ready;
  logic [gcd_pkg::RAD_W-1:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface
`default_nettype wire

[rtl/great_circle_distance.sv]
// Great-circle distance by the spherical law of cosines.
// pts: request with two points (lat/lon in degrees * 65536) and a missing flag
//   per point; taken when valid and ready are high at a clock edge.
// res: one result per request, in order: distance in whole meters, saturated,
//   and result_missing (distance then 0). Identical points give 0.
// cfg: write of the sphere radius in meters; always ready, takes effect on the
//   next request. Write it only while no request is in flight.
// Throughput: one request per cycle while the output buffer is not full. The
//   datapath is the sine/cosine CORDIC, the 31-step square root and the
//   arccosine CORDIC in series.
// Stalls: the pipeline halts as a whole while the two-entry output buffer is
//   full; pts.ready comes from a register, so nothing is lost or repeated.
// Reset (rst, synchronous): pipeline and output emptied, radius back to
//   6378137 m.
`default_nettype none
module great_circle_distance #(
  parameter int CORDIC_STAGES = gcd_pkg::CORDIC_STAGES_DEF
) (
  input  logic clk,
  input  logic rst,
  gcd_pts_if.sink   pts,
  gcd_res_if.source res,
  gcd_cfg_if.sink   cfg
);

  typedef struct packed {
    logic [gcd_pkg::DIST_W-1:0] dist_m;
    logic missing;
  } res_t;

  logic [gcd_pkg::RAD_W-1:0] radius;
  logic en, skid_v, out_v;
  res_t out_d, skid_d, new_d;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= gcd_pkg::RADIUS_RESET;
    end else if (cfg.valid) begin
      radius <= cfg.data;
    end
  end

  assign en        = !skid_v;
  assign pts.ready = en;

  gcd_pkg::ctl_t c_f, c_s, c_r, c_a, c_m;
  gcd_pkg::ang_t z_f [3];
  logic flip_f [3];
  gcd_pkg::ang_t s_s [3];
  gcd_pkg::ang_t c_sc [3];
  logic signed [31:0] r_r;
  logic [gcd_pkg::SQRT_W-1:0] s_r;
  logic [gcd_pkg::THETA_W-1:0] theta;

  gcd_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(pts.valid),
    .lat_a(pts.lat_a), .lon_a(pts.lon_a), .lat_b(pts.lat_b), .lon_b(pts.lon_b),
    .a_missing(pts.a_missing), .b_missing(pts.b_missing),
    .co(c_f), .z_out(z_f), .flip_out(flip_f)
  );

  gcd_sincos #(.STAGES(CORDIC_STAGES)) u_sincos (
    .clk(clk), .rst(rst), .en(en), .ci(c_f), .z_in(z_f), .flip_in(flip_f),
    .co(c_s), .s_out(s_s), .c_out(c_sc)
  );

  gcd_ratio u_ratio (
    .clk(clk), .rst(rst), .en(en), .ci(c_s), .s_in(s_s), .c_in(c_sc),
    .co(c_r), .r_out(r_r), .s_out(s_r)
  );

  gcd_acos #(.STAGES(CORDIC_STAGES)) u_acos (
    .clk(clk), .rst(rst), .en(en), .ci(c_r), .r_in(r_r), .s_in(s_r),
    .co(c_a), .theta(theta)
  );

  // radius scaling
  logic [55:0] prod;
  logic [25:0] q;
  logic push, fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_m <= '0;
    end else if (en) begin
      c_m <= c_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= 56'(theta) * 56'(radius);
    end
  end

  assign q = 26'((prod + 56'd536870912) >> 30);

  always_comb begin
    new_d.missing = c_m.missing;
    if (c_m.zero) begin
      new_d.dist_m = '0;
    end else if (q > 26'(gcd_pkg::DIST_MAX)) begin
      new_d.dist_m = gcd_pkg::DIST_MAX;
    end else begin
      new_d.dist_m = q[gcd_pkg::DIST_W-1:0];
    end
  end

  // output register plus skid entry
  assign push = en && c_m.valid;
  assign fire = out_v && res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (fire) begin
        out_d  <= skid_d;
        skid_v <= 1'b0;
      end
    end else if (push) begin
      if (!out_v || fire) begin
        out_d <= new_d;
        out_v <= 1'b1;
      end else begin
        skid_d <= new_d;
        skid_v <= 1'b1;
      end
    end else if (fire) begin
      out_v <= 1'b0;
    end
  end

  assign res.valid          = out_v;
  assign res.distance_m     = out_d.dist_m;
  assign res.result_missing = out_d.missing;

endmodule
`default_nettype wire

[rtl/gcd_front.sv]
`default_nettype none
module gcd_front (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic signed [gcd_pkg::LAT_W-1:0] lat_a,
  input  logic signed [gcd_pkg::LON_W-1:0] lon_a,
  input  logic signed [gcd_pkg::LAT_W-1:0] lat_b,
  input  logic signed [gcd_pkg::LON_W-1:0] lon_b,
  input  logic a_missing,
  input  logic b_missing,
  output gcd_pkg::ctl_t co,
  output gcd_pkg::ang_t z_out [3],
  output logic flip_out [3]
);

  localparam logic [27:0] FULL_1 = 28'd23592960;
  localparam logic [27:0] FULL_2 = 28'd47185920;
  localparam logic [27:0] FULL_4 = 28'd94371840;
  localparam logic signed [28:0] OFFSET = 29'sd82575360;  // half turn + three turns
  localparam logic signed [24:0] DH = 25'sd11796480;
  localparam logic signed [24:0] DQ = 25'sd5898240;

  // {flip, folded angle} with the angle in [-90, 90] degrees
  function automatic logic [24:0] fold(input logic signed [24:0] d);
    logic [24:0] r;
    if (d > DQ) begin
      r = {1'b1, 24'(DH - d)};
    end else if (d < -DQ) begin
      r = {1'b1, 24'(-DH - d)};
    end else begin
      r = {1'b0, 24'(d)};
    end
    return r;
  endfunction

  // stage 1
  gcd_pkg::ctl_t c1;
  logic signed [gcd_pkg::LAT_W-1:0] la1, lb1;
  logic [27:0] t1;
  logic signed [26:0] dl;
  logic [27:0] t0;

  assign dl = 27'(lon_b) - 27'(lon_a);
  assign t0 = 28'(29'(dl) + OFFSET);

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
    end else if (en) begin
      c1.valid   <= in_valid;
      c1.missing <= a_missing | b_missing;
      c1.zero    <= a_missing | b_missing | ((lat_a == lat_b) && (lon_a == lon_b));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      la1 <= lat_a;
      lb1 <= lat_b;
      t1  <= (t0 >= FULL_4) ? t0 - FULL_4 : t0;
    end
  end

  // stage 2
  gcd_pkg::ctl_t c2;
  logic [27:0] t2a, t2b;
  logic signed [24:0] dd;
  logic [24:0] f_la, f_lb, f_dl;
  logic signed [23:0] d2 [3];
  logic flip2 [3];

  assign t2a = (t1 >= FULL_2) ? t1 - FULL_2 : t1;
  assign t2b = (t2a >= FULL_1) ? t2a - FULL_1 : t2a;
  assign dd  = 25'(t2b) - DH;
  assign f_la = fold(25'(la1));
  assign f_lb = fold(25'(lb1));
  assign f_dl = fold(dd);

  always_ff @(posedge clk) begin
    if (rst) begin
      c2 <= '0;
    end else if (en) begin
      c2 <= c1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2[0] <= f_la[23:0];
      d2[1] <= f_lb[23:0];
      d2[2] <= f_dl[23:0];
      flip2[0] <= f_la[24];
      flip2[1] <= f_lb[24];
      flip2[2] <= f_dl[24];
    end
  end

  // stage 3: degrees*65536 to Q4.30 radians
  always_ff @(posedge clk) begin
    if (rst) begin
      co <= '0;
    end else if (en) begin
      co <= c2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        z_out[l] <= gcd_pkg::ang_t'((52'(d2[l]) * 52'sd74961321 + 52'sd131072) >>> 18);
        flip_out[l] <= flip2[l];
      end
    end
  end

endmodule
`default_nettype wire

[rtl/gcd_sincos.sv]
`default_nettype none
module gcd_sincos #(
  parameter int STAGES = gcd_pkg::CORDIC_STAGES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  gcd_pkg::ctl_t ci,
  input  gcd_pkg::ang_t z_in [3],
  input  logic flip_in [3],
  output gcd_pkg::ctl_t co,
  output gcd_pkg::ang_t s_out [3],
  output gcd_pkg::ang_t c_out [3]
);

  gcd_pkg::ang_t x [1:STAGES][3];
  gcd_pkg::ang_t y [1:STAGES][3];
  gcd_pkg::ang_t z [1:STAGES][3];
  logic fl [1:STAGES][3];
  gcd_pkg::ctl_t cs [1:STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_st
    gcd_pkg::ang_t xp [3];
    gcd_pkg::ang_t yp [3];
    gcd_pkg::ang_t zp [3];
    logic fp [3];
    gcd_pkg::ctl_t cp;

    if (i == 0) begin : g_first
      assign xp = '{gcd_pkg::INV_GAIN, gcd_pkg::INV_GAIN, gcd_pkg::INV_GAIN};
      assign yp = '{default: '0};
      assign zp = z_in;
      assign fp = flip_in;
      assign cp = ci;
    end else begin : g_rest
      assign xp = x[i];
      assign yp = y[i];
      assign zp = z[i];
      assign fp = fl[i];
      assign cp = cs[i];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        cs[i+1] <= '0;
      end else if (en) begin
        cs[i+1] <= cp;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          if (zp[l] >= 0) begin
            x[i+1][l] <= xp[l] - (yp[l] >>> i);
            y[i+1][l] <= yp[l] + (xp[l] >>> i);
            z[i+1][l] <= zp[l] - gcd_pkg::atan_step(i);
          end else begin
            x[i+1][l] <= xp[l] + (yp[l] >>> i);
            y[i+1][l] <= yp[l] - (xp[l] >>> i);
            z[i+1][l] <= zp[l] + gcd_pkg::atan_step(i);
          end
          fl[i+1][l] <= fp[l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      co <= '0;
    end else if (en) begin
      co <= cs[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        s_out[l] <= y[STAGES][l];
        c_out[l] <= fl[STAGES][l] ? -x[STAGES][l] : x[STAGES][l];
      end
    end
  end

endmodule
`default_nettype wire

[rtl/gcd_ratio.sv]
`default_nettype none
module gcd_ratio (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  gcd_pkg::ctl_t ci,
  input  gcd_pkg::ang_t s_in [3],
  input  gcd_pkg::ang_t c_in [3],
  output gcd_pkg::ctl_t co,
  output logic signed [31:0] r_out,
  output logic [gcd_pkg::SQRT_W-1:0] s_out
);

  localparam int PW = 2 * gcd_pkg::ANG_W;
  localparam int SQ_STEPS = gcd_pkg::SQRT_W;

  function automatic gcd_pkg::ang_t rnd(input logic signed [PW-1:0] p);
    return gcd_pkg::ang_t'((p + PW'(64'sd536870912)) >>> 30);
  endfunction

  gcd_pkg::ctl_t c1, c2, c3, c4;
  gcd_pkg::ang_t p1, p2, cd1, p3, p2b;
  logic signed [31:0] r3, r4;
  logic [60:0] sq4;
  logic signed [gcd_pkg::ANG_W:0] sum;
  logic signed [63:0] r3sq;

  assign sum  = (gcd_pkg::ANG_W+1)'(p3) + (gcd_pkg::ANG_W+1)'(p2b);
  assign r3sq = 64'(r3) * 64'(r3);

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      c3 <= '0;
      c4 <= '0;
    end else if (en) begin
      c1 <= ci;
      c2 <= c1;
      c3 <= c2;
      c4 <= c3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1  <= rnd(PW'(c_in[0]) * PW'(c_in[1]));
      p2  <= rnd(PW'(s_in[0]) * PW'(s_in[1]));
      cd1 <= c_in[2];
      p3  <= rnd(PW'(p1) * PW'(cd1));
      p2b <= p2;
      if (sum > (gcd_pkg::ANG_W+1)'(gcd_pkg::ONE_Q30) ||
          sum < -((gcd_pkg::ANG_W+1)'(gcd_pkg::ONE_Q30))) begin
        r3 <= 32'(gcd_pkg::ONE_Q30);
      end else begin
        r3 <= 32'(sum);
      end
      r4  <= r3;
      sq4 <= 61'(64'sh1000_0000_0000_0000 - r3sq);
    end
  end

  // digit-by-digit square root, one result bit per stage
  logic [32:0] rem [1:SQ_STEPS];
  logic [gcd_pkg::SQRT_W-1:0] root [1:SQ_STEPS];
  logic [61:0] rad [1:SQ_STEPS];
  logic signed [31:0] rr [1:SQ_STEPS];
  gcd_pkg::ctl_t cq [1:SQ_STEPS];

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
    logic [32:0] rem_p;
    logic [gcd_pkg::SQRT_W-1:0] root_p;
    logic [61:0] rad_p;
    logic signed [31:0] rr_p;
    gcd_pkg::ctl_t cp;
    logic [32:0] cur, trial;

    if (j == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = {1'b0, sq4};
      assign rr_p   = r4;
      assign cp     = c4;
    end else begin : g_rest
      assign rem_p  = rem[j];
      assign root_p = root[j];
      assign rad_p  = rad[j];
      assign rr_p   = rr[j];
      assign cp     = cq[j];
    end

    assign cur   = {rem_p[30:0], rad_p[61-2*j -: 2]};
    assign trial = {root_p, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        cq[j+1] <= '0;
      end else if (en) begin
        cq[j+1] <= cp;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (cur >= trial) begin
          rem[j+1]  <= cur - trial;
          root[j+1] <= {root_p[gcd_pkg::SQRT_W-2:0], 1'b1};
        end else begin
          rem[j+1]  <= cur;
          root[j+1] <= {root_p[gcd_pkg::SQRT_W-2:0], 1'b0};
        end
        rad[j+1] <= rad_p;
        rr[j+1]  <= rr_p;
      end
    end
  end

  assign co    = cq[SQ_STEPS];
  assign r_out = rr[SQ_STEPS];
  assign s_out = root[SQ_STEPS];

endmodule
`default_nettype wire

[rtl/gcd_acos.sv]
`default_nettype none
module gcd_acos #(
  parameter int STAGES = gcd_pkg::CORDIC_STAGES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  gcd_pkg::ctl_t ci,
  input  logic signed [31:0] r_in,
  input  logic [gcd_pkg::SQRT_W-1:0] s_in,
  output gcd_pkg::ctl_t co,
  output logic [gcd_pkg::THETA_W-1:0] theta
);

  gcd_pkg::ctl_t c0;
  gcd_pkg::ang_t x0, y0, z0;

  always_ff @(posedge clk) begin
    if (rst) begin
      c0 <= '0;
    end else if (en) begin
      c0 <= ci;
    end
  end

  // negative ratio: pre-rotate by -90 degrees
  always_ff @(posedge clk) begin
    if (en) begin
      if (r_in < 0) begin
        x0 <= gcd_pkg::ang_t'(s_in);
        y0 <= -gcd_pkg::ang_t'(r_in);
        z0 <= gcd_pkg::HALF_PI;
      end else begin
        x0 <= gcd_pkg::ang_t'(r_in);
        y0 <= gcd_pkg::ang_t'(s_in);
        z0 <= '0;
      end
    end
  end

  gcd_pkg::ang_t x [1:STAGES];
  gcd_pkg::ang_t y [1:STAGES];
  gcd_pkg::ang_t z [1:STAGES];
  gcd_pkg::ctl_t cs [1:STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_st
    gcd_pkg::ang_t xp, yp, zp;
    gcd_pkg::ctl_t cp;

    if (i == 0) begin : g_first
      assign xp = x0;
      assign yp = y0;
      assign zp = z0;
      assign cp = c0;
    end else begin : g_rest
      assign xp = x[i];
      assign yp = y[i];
      assign zp = z[i];
      assign cp = cs[i];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        cs[i+1] <= '0;
      end else if (en) begin
        cs[i+1] <= cp;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (yp > 0) begin
          x[i+1] <= xp + (yp >>> i);
          y[i+1] <= yp - (xp >>> i);
          z[i+1] <= zp + gcd_pkg::atan_step(i);
        end else begin
          x[i+1] <= xp - (yp >>> i);
          y[i+1] <= yp + (xp >>> i);
          z[i+1] <= zp - gcd_pkg::atan_step(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      co <= '0;
    end else if (en) begin
      co <= cs[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      theta <= (z[STAGES] < 0) ? '0 : gcd_pkg::THETA_W'(z[STAGES]);
    end
  end

endmodule
`default_nettype wire

[rtl/gcd_checker.sv]
`default_nettype none
`include "great_circle_distance_macros.svh"
module gcd_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [gcd_pkg::DIST_W-1:0] distance_m,
  input logic result_missing
);

  `GCD_ASSERT(a_missing_zero, clk, rst, out_valid && result_missing, distance_m == '0, "missing point with nonzero distance")
  `GCD_ASSERT(a_dist_max, clk, rst, out_valid, distance_m <= gcd_pkg::DIST_MAX, "distance above saturation limit")
  `GCD_ASSERT_NXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(distance_m) && $stable(result_missing), "stalled result changed")
  `GCD_ASSERT_RST(a_reset, clk, rst, !out_valid && in_ready, "not empty after reset")

endmodule

bind great_circle_distance gcd_checker u_gcd_checker (
  .clk(clk), .rst(rst), .in_ready(pts.ready),
  .out_valid(res.valid), .out_ready(res.ready),
  .distance_m(res.distance_m), .result_missing(res.result_missing)
);
`default_nettype wire
